// File: src/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants of the button click detector
// Event codes, register indexes, configuration and result-group types, and
// saturating helpers for the tick counters.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int REG_WIDTH  = 16;
  localparam int IDX_WIDTH  = 3;
  localparam int MAX_EVENTS = 3;
  localparam int NUM_SRC    = 7;

  typedef logic [TIME_WIDTH-1:0] tick_t;
  typedef logic [REG_WIDTH-1:0]  regval_t;

  typedef enum logic [2:0] {
    EV_PRESSED  = 3'd0,
    EV_RELEASED = 3'd1,
    EV_CLICK    = 3'd2,
    EV_DOUBLE   = 3'd3,
    EV_LONG     = 3'd4,
    EV_HOLD     = 3'd5
  } event_e;

  localparam logic [IDX_WIDTH-1:0] REG_PIN_INVERT   = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_DOUBLE_CLICK = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_REPEAT       = 3'd4;

  // Emission order of the possible events of one tick.
  localparam logic [NUM_SRC-1:0][2:0] EVENT_ORDER = {
    EV_CLICK, EV_HOLD, EV_LONG, EV_CLICK, EV_DOUBLE, EV_RELEASED, EV_PRESSED
  };

  typedef struct packed {
    logic    pin_invert;
    regval_t debounce_ticks;
    regval_t long_press_ticks;
    regval_t double_click_ticks;
    regval_t repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                 count;
    logic [MAX_EVENTS-1:0][2:0] codes;   // codes[0] goes out first
  } evgrp_t;

  function automatic tick_t ext_reg(input regval_t v);
    ext_reg = {{(TIME_WIDTH-REG_WIDTH){1'b0}}, v};
  endfunction

  function automatic tick_t sat_add(input tick_t a, input regval_t b);
    logic [TIME_WIDTH:0] sum;
    sum = {1'b0, a} + {{(TIME_WIDTH+1-REG_WIDTH){1'b0}}, b};
    sat_add = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
  endfunction

  function automatic tick_t sat_inc(input tick_t a);
    sat_inc = (a == '1) ? a : a + tick_t'(1);
  endfunction

endpackage

// File: src/bcd_cfg.sv
// ----------------------------------------------------------------------------
// bcd_cfg: configuration registers
// Write-only register file holding polarity and the tick thresholds.
// ----------------------------------------------------------------------------
module bcd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bcd_pkg::IDX_WIDTH-1:0] cfg_index,
  input  logic [bcd_pkg::REG_WIDTH-1:0] cfg_data,
  output bcd_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_invert         <= 1'b0;
      cfg.debounce_ticks     <= 16'd2;
      cfg.long_press_ticks   <= 16'd150;
      cfg.double_click_ticks <= 16'd30;
      cfg.repeat_ticks       <= 16'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcd_pkg::REG_PIN_INVERT:   cfg.pin_invert         <= cfg_data[0];
        bcd_pkg::REG_DEBOUNCE:     cfg.debounce_ticks     <= cfg_data;
        bcd_pkg::REG_LONG_PRESS:   cfg.long_press_ticks   <= cfg_data;
        bcd_pkg::REG_DOUBLE_CLICK: cfg.double_click_ticks <= cfg_data;
        bcd_pkg::REG_REPEAT:       cfg.repeat_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/bcd_core.sv
// ----------------------------------------------------------------------------
// bcd_core: debounce and gesture state
// Updates the debounce, hold and click state once per accepted tick and
// forms the group of events caused by that tick.
// ----------------------------------------------------------------------------
module bcd_core (
  input  logic             clk,
  input  logic             rst,
  input  bcd_pkg::cfg_t    cfg,
  input  logic             tick,       // a tick beat is accepted
  input  logic             pin_level,
  output bcd_pkg::evgrp_t  grp
);

  logic           raw_previous, raw_previous_next;
  bcd_pkg::tick_t ticks_since_raw_change, ticks_since_raw_change_next;
  logic           debounced_down, debounced_down_next;
  bcd_pkg::tick_t held_ticks, held_ticks_next;
  logic           long_reached, long_reached_next;
  bcd_pkg::tick_t next_repeat_at, next_repeat_at_next;
  logic           click_pending, click_pending_next;
  bcd_pkg::tick_t ticks_since_first_click, ticks_since_first_click_next;

  logic                        pressed;
  logic [bcd_pkg::NUM_SRC-1:0] hit;
  logic [1:0]                  cnt;

  always_comb begin
    pressed = cfg.pin_invert ? ~pin_level : pin_level;
    hit     = '0;

    raw_previous_next            = raw_previous;
    debounced_down_next          = debounced_down;
    long_reached_next            = long_reached;
    next_repeat_at_next          = next_repeat_at;
    click_pending_next           = click_pending;
    held_ticks_next              = debounced_down ? bcd_pkg::sat_inc(held_ticks) : held_ticks;
    ticks_since_first_click_next = click_pending ? bcd_pkg::sat_inc(ticks_since_first_click)
                                                 : ticks_since_first_click;

    if (pressed != raw_previous) begin
      raw_previous_next          = pressed;
      ticks_since_raw_change_next = '0;
    end else begin
      ticks_since_raw_change_next = bcd_pkg::sat_inc(ticks_since_raw_change);
    end

    if (ticks_since_raw_change_next > bcd_pkg::ext_reg(cfg.debounce_ticks)) begin
      if (pressed != debounced_down) begin
        debounced_down_next = pressed;
        if (pressed) begin
          hit[0]            = 1'b1;
          held_ticks_next   = '0;
          long_reached_next = 1'b0;
        end else begin
          hit[1] = 1'b1;
          if (long_reached) begin
            // A release that ends a long press is never a click.
            click_pending_next = 1'b0;
            long_reached_next  = 1'b0;
          end else if (!click_pending) begin
            click_pending_next           = 1'b1;
            ticks_since_first_click_next = '0;
          end else if (ticks_since_first_click_next <=
                       bcd_pkg::ext_reg(cfg.double_click_ticks)) begin
            hit[2]             = 1'b1;
            click_pending_next = 1'b0;
          end else begin
            // Late second click: report the first one and start a new window.
            hit[3]                       = 1'b1;
            click_pending_next           = 1'b1;
            ticks_since_first_click_next = '0;
          end
        end
      end

      if (debounced_down_next) begin
        if (!long_reached_next &&
            held_ticks_next > bcd_pkg::ext_reg(cfg.long_press_ticks)) begin
          hit[4]              = 1'b1;
          long_reached_next   = 1'b1;
          next_repeat_at_next = bcd_pkg::sat_add(bcd_pkg::ext_reg(cfg.long_press_ticks),
                                                 cfg.repeat_ticks);
        end
        if (long_reached_next && held_ticks_next > next_repeat_at_next) begin
          hit[5]              = 1'b1;
          next_repeat_at_next = bcd_pkg::sat_add(next_repeat_at_next, cfg.repeat_ticks);
        end
      end
    end

    if (click_pending_next &&
        ticks_since_first_click_next > bcd_pkg::ext_reg(cfg.double_click_ticks)) begin
      hit[6]             = 1'b1;
      click_pending_next = 1'b0;
    end
  end

  // Pack the raised events in emission order, at most three per tick.
  always_comb begin
    cnt       = 2'd0;
    grp.codes = '0;
    for (int i = 0; i < bcd_pkg::NUM_SRC; i++) begin
      if (hit[i] && cnt < 2'(bcd_pkg::MAX_EVENTS)) begin
        grp.codes[cnt] = bcd_pkg::EVENT_ORDER[i];
        cnt            = cnt + 2'd1;
      end
    end
    grp.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous            <= 1'b0;
      ticks_since_raw_change  <= '1;
      debounced_down          <= 1'b0;
      held_ticks              <= '0;
      long_reached            <= 1'b0;
      next_repeat_at          <= '0;
      click_pending           <= 1'b0;
      ticks_since_first_click <= '0;
    end else if (tick) begin
      raw_previous            <= raw_previous_next;
      ticks_since_raw_change  <= ticks_since_raw_change_next;
      debounced_down          <= debounced_down_next;
      held_ticks              <= held_ticks_next;
      long_reached            <= long_reached_next;
      next_repeat_at          <= next_repeat_at_next;
      click_pending           <= click_pending_next;
      ticks_since_first_click <= ticks_since_first_click_next;
    end
  end

  // A long press can only be in effect while the key is debounced down.
  a_long_needs_down: assert property (@(posedge clk) disable iff (rst)
    long_reached |-> debounced_down)
    else $error("long press flag set while key is released");

  // State moves only on an accepted tick.
  a_hold_without_tick: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(tick) |-> $stable(held_ticks) && $stable(click_pending))
    else $error("state changed without a tick");

  // A press edge always leads its tick's group.
  a_press_first: assert property (@(posedge clk) disable iff (rst)
    hit[0] |-> grp.codes[0] == bcd_pkg::EV_PRESSED)
    else $error("pressed event not first in group");

endmodule

// File: src/bcd_evq.sv
// ----------------------------------------------------------------------------
// bcd_evq: event output buffer
// Holds the event group of one tick and sends it out one beat per event.
// ----------------------------------------------------------------------------
module bcd_evq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  bcd_pkg::evgrp_t grp,
  output logic            load_ready,
  output logic            m_valid,
  input  logic            m_ready,
  output logic [2:0]      m_code,
  output logic            m_last
);

  logic [1:0]                          rem;
  logic [bcd_pkg::MAX_EVENTS-1:0][2:0] codes;
  logic                                take;

  assign m_valid    = (rem != 2'd0);
  assign take       = m_valid && m_ready;
  assign m_code     = codes[0];
  assign m_last     = (rem == 2'd1);
  // A new group may enter while the final event of the current one leaves.
  assign load_ready = !m_valid || (m_last && m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= grp.count;
    end else if (take) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      codes <= grp.codes;
    end else if (take) begin
      codes <= {3'd0, codes[bcd_pkg::MAX_EVENTS-1:1]};
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load && grp.count != 2'd0 |=> m_valid && m_code == $past(grp.codes[0]))
    else $error("loaded group not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !m_valid || (m_last && m_ready))
    else $error("group loaded over pending events");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> m_code <= bcd_pkg::EV_HOLD)
    else $error("event code out of range");

endmodule

// File: src/button_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// button_click_long_press_detector: button debounce and gesture events
// Debounces one scan tick per beat and reports pressed, released, click,
// double click, long press and hold repeat events.
//
//   Channel   Dir  Beat content
//   s_axis    in   tdata[0] pin_level, one beat per scan tick
//   m_axis    out  tdata[2:0] event_code, tlast last_event
//   cfg       in   cfg_we / cfg_index / cfg_data, register write
//
// A tick beat is taken every cycle while its events leave one per cycle;
// a tick causing two or three events holds s_axis_tready low for the extra
// beats. The first event appears in the cycle after its tick is accepted.
// Reset (rst, synchronous) means released, with the raw-change count
// saturated. A stall on m_axis holds the buffered events and stops intake.
// ----------------------------------------------------------------------------
module button_click_long_press_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [0] pin_level
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [2:0] event_code
  output logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [bcd_pkg::IDX_WIDTH-1:0] cfg_index,
  input  logic [bcd_pkg::REG_WIDTH-1:0] cfg_data
);

  bcd_pkg::cfg_t   cfg;
  bcd_pkg::evgrp_t grp;
  logic            tick;
  logic [2:0]      code;

  assign tick         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {5'd0, code};

  bcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tick      (tick),
    .pin_level (s_axis_tdata[0]),
    .grp       (grp)
  );

  bcd_evq u_evq (
    .clk        (clk),
    .rst        (rst),
    .load       (tick),
    .grp        (grp),
    .load_ready (s_axis_tready),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_code     (code),
    .m_last     (m_axis_tlast)
  );

endmodule

// File: dv/tb_button_click_long_press_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_click_long_press_detector: self-checking bench of the detector
// Sends one pin sample per beat as press and release gestures of random
// length, with 1 to 4 noise samples mixed in, under several register settings.
// Expected events come from a tick-level model of debounce, click timing, long
// press and hold repeat, and are compared beat by beat with the event stream.
// ----------------------------------------------------------------------------
module tb_button_click_long_press_detector;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    bcd_pkg::event_e code;
    logic            last;
  } event_beat_t;

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;   // [0] pin_level
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;   // [2:0] event_code
  logic                          m_axis_tlast;   // last_event
  logic                          cfg_we;
  logic [bcd_pkg::IDX_WIDTH-1:0] cfg_index;
  logic [bcd_pkg::REG_WIDTH-1:0] cfg_data;

  button_click_long_press_detector u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Register copies seen by the event model.
  logic             cur_pin_invert;
  bcd_pkg::regval_t cur_debounce;
  bcd_pkg::regval_t cur_long;
  bcd_pkg::regval_t cur_double;
  bcd_pkg::regval_t cur_repeat;

  // Event model state.
  logic           raw_seen;
  bcd_pkg::tick_t quiet_ticks;
  logic           key_down;
  bcd_pkg::tick_t down_ticks;
  logic           long_fired;
  bcd_pkg::tick_t repeat_mark;
  logic           click_open;
  bcd_pkg::tick_t click_age;

  logic        pin_q[$];
  event_beat_t due_events[$];

  int unsigned error_count;
  int unsigned cycle_count;
  bit          tick_busy;
  bit          tick_taken;
  bit          event_taken;
  int unsigned tick_gap;
  int unsigned event_stall;
  int unsigned tick_calm;
  int unsigned event_calm;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_pin_invert = 1'b0;
    cur_debounce = 16'd2;
    cur_long = 16'd150;
    cur_double = 16'd30;
    cur_repeat = 16'd20;
    raw_seen = 1'b0;
    quiet_ticks = '1;
    key_down = 1'b0;
    down_ticks = '0;
    long_fired = 1'b0;
    repeat_mark = '0;
    click_open = 1'b0;
    click_age = '0;
    error_count = 0;
    cycle_count = 0;
    tick_busy = 1'b0;
    tick_taken = 1'b0;
    event_taken = 1'b0;
    tick_gap = 0;
    event_stall = 0;
    tick_calm = 0;
    event_calm = 0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bcd_pkg::tick_t sat_sum(input bcd_pkg::tick_t a,
                                             input bcd_pkg::tick_t b);
    logic [bcd_pkg::TIME_WIDTH:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[bcd_pkg::TIME_WIDTH] ? '1 : total[bcd_pkg::TIME_WIDTH-1:0];
  endfunction

  // Wait drawn for each beat; a calm stretch forces back-to-back beats.
  function automatic int unsigned pick_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 1) ? $urandom_range(0, 16) : 0;
  endfunction

  // Advances the model by one scan tick and queues the events it raises.
  function automatic void predict_tick(input logic pin);
    logic            down_now;
    bcd_pkg::event_e raised[$];
    down_now = cur_pin_invert ? !pin : pin;
    if (key_down) down_ticks = sat_sum(down_ticks, 1);
    if (click_open) click_age = sat_sum(click_age, 1);
    if (down_now != raw_seen) begin
      raw_seen = down_now;
      quiet_ticks = '0;
    end else begin
      quiet_ticks = sat_sum(quiet_ticks, 1);
    end
    if (quiet_ticks > bcd_pkg::ext_reg(cur_debounce)) begin
      if (down_now != key_down) begin
        key_down = down_now;
        if (down_now) begin
          raised.push_back(bcd_pkg::EV_PRESSED);
          down_ticks = '0;
          long_fired = 1'b0;
        end else begin
          raised.push_back(bcd_pkg::EV_RELEASED);
          if (long_fired) begin
            click_open = 1'b0;
            long_fired = 1'b0;
          end else if (!click_open) begin
            click_open = 1'b1;
            click_age = '0;
          end else if (click_age <= bcd_pkg::ext_reg(cur_double)) begin
            raised.push_back(bcd_pkg::EV_DOUBLE);
            click_open = 1'b0;
          end else begin
            // A second click past the window flushes the first and opens anew.
            raised.push_back(bcd_pkg::EV_CLICK);
            click_age = '0;
          end
        end
      end
      if (key_down) begin
        if (!long_fired && down_ticks > bcd_pkg::ext_reg(cur_long)) begin
          raised.push_back(bcd_pkg::EV_LONG);
          long_fired = 1'b1;
          repeat_mark = sat_sum(bcd_pkg::ext_reg(cur_long), bcd_pkg::ext_reg(cur_repeat));
        end
        if (long_fired && down_ticks > repeat_mark) begin
          raised.push_back(bcd_pkg::EV_HOLD);
          repeat_mark = sat_sum(repeat_mark, bcd_pkg::ext_reg(cur_repeat));
        end
      end
    end
    if (click_open && click_age > bcd_pkg::ext_reg(cur_double)) begin
      raised.push_back(bcd_pkg::EV_CLICK);
      click_open = 1'b0;
    end
    foreach (raised[i]) due_events.push_back('{raised[i], i == raised.size() - 1});
  endfunction

  // Sampling of both channels at the rising edge.
  always @(posedge clk) begin
    event_beat_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        event_taken = 1'b1;
        if (due_events.size() == 0) begin
          $error("unexpected event beat: event_code %0d, last_event %0b",
                 m_axis_tdata[2:0], m_axis_tlast);
          error_count++;
        end else begin
          want = due_events.pop_front();
          if (m_axis_tdata[2:0] != want.code) begin
            $error("event_code: expected %0d, actual %0d", want.code, m_axis_tdata[2:0]);
            error_count++;
          end
          if (m_axis_tlast != want.last) begin
            $error("last_event: expected %0b, actual %0b", want.last, m_axis_tlast);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tick_taken = 1'b1;
        predict_tick(s_axis_tdata[0]);
      end
    end
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("button_click_long_press_detector: mismatch");
      $finish;
    end
  end

  // Tick driver.
  always @(negedge clk) begin
    if (!rst) begin
      if (tick_taken) begin
        tick_taken = 1'b0;
        tick_busy = 1'b0;
      end
      if (!tick_busy) begin
        if (tick_gap > 0) begin
          tick_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pin_q.size() > 0) begin
          s_axis_tdata <= {7'b0, pin_q.pop_front()};
          s_axis_tvalid <= 1'b1;
          tick_busy = 1'b1;
          tick_gap = pick_wait(tick_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Event receiver back-pressure.
  always @(negedge clk) begin
    if (!rst) begin
      if (event_taken) begin
        event_taken = 1'b0;
        event_stall = pick_wait(event_calm);
      end
      if (event_stall > 0) begin
        event_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic settle();
    while (pin_q.size() != 0 || tick_busy || due_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bcd_pkg::IDX_WIDTH-1:0] idx,
                           input bcd_pkg::regval_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bcd_pkg::REG_PIN_INVERT:   cur_pin_invert = val[0];
      bcd_pkg::REG_DEBOUNCE:     cur_debounce = val;
      bcd_pkg::REG_LONG_PRESS:   cur_long = val;
      bcd_pkg::REG_DOUBLE_CLICK: cur_double = val;
      bcd_pkg::REG_REPEAT:       cur_repeat = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic inv, input bcd_pkg::regval_t deb,
                           input bcd_pkg::regval_t lp, input bcd_pkg::regval_t dc,
                           input bcd_pkg::regval_t rp);
    settle();
    write_reg(bcd_pkg::REG_PIN_INVERT, bcd_pkg::regval_t'(inv));
    write_reg(bcd_pkg::REG_DEBOUNCE, deb);
    write_reg(bcd_pkg::REG_LONG_PRESS, lp);
    write_reg(bcd_pkg::REG_DOUBLE_CLICK, dc);
    write_reg(bcd_pkg::REG_REPEAT, rp);
  endtask

  task automatic queue_level(input logic down, input int unsigned n);
    repeat (n) pin_q.push_back(cur_pin_invert ? !down : down);
  endtask

  task automatic random_config();
    configure(1'($urandom_range(0, 1)), bcd_pkg::regval_t'($urandom_range(0, 4)),
              bcd_pkg::regval_t'($urandom_range(1, 12)),
              bcd_pkg::regval_t'($urandom_range(1, 16)),
              bcd_pkg::regval_t'($urandom_range(1, 5)));
  endtask

  // Mostly complete press/release gestures that clear the debounce, with
  // some long enough to reach long press and repeats, plus pin noise.
  task automatic random_gestures(input int unsigned n_ticks);
    int unsigned queued;
    int unsigned settle_len;
    int unsigned press_len;
    int unsigned release_len;
    int unsigned noise_len;
    queued = 0;
    settle_len = int'(cur_debounce) + 1;
    while (queued < n_ticks) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 2) == 0)
          press_len = settle_len + int'(cur_long) + $urandom_range(0, 3 * int'(cur_repeat) + 2);
        else
          press_len = settle_len + $urandom_range(0, 3);
        release_len = settle_len + $urandom_range(0, int'(cur_double) + 3);
        queue_level(1'b1, press_len);
        queue_level(1'b0, release_len);
        queued += press_len + release_len;
      end else begin
        noise_len = $urandom_range(1, 4);
        repeat (noise_len) pin_q.push_back(1'($urandom_range(0, 1)));
        queued += noise_len;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: debounce of zero, long press threshold of one tick, window of four ticks.
    configure(1'b0, 16'd0, 16'd1, 16'd4, 16'd1);
    queue_level(1'b1, 5);   // pressed, long press, hold repeat
    queue_level(1'b0, 2);   // release after long press drops the click
    queue_level(1'b1, 2);
    queue_level(1'b0, 2);   // first click opens the window
    queue_level(1'b1, 2);
    queue_level(1'b0, 2);   // double click
    queue_level(1'b1, 2);
    queue_level(1'b0, 2);
    queue_level(1'b1, 3);
    queue_level(1'b0, 7);   // late second click, then a timed-out click

    random_config();
    random_gestures(40);
    configure(1'b1, 16'd0, 16'd1, 16'd1, 16'd1);
    random_gestures(30);
    configure(1'b1, bcd_pkg::regval_t'($urandom_range(0, 4)),
              bcd_pkg::regval_t'($urandom_range(1, 12)),
              bcd_pkg::regval_t'($urandom_range(1, 16)),
              bcd_pkg::regval_t'($urandom_range(1, 5)));
    random_gestures(40);
    // Widest registers: nothing gets past the debounce here.
    configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (20) pin_q.push_back(1'($urandom_range(0, 1)));
    random_config();
    random_gestures(40);
    random_config();
    random_gestures(30);

    settle();
    if (due_events.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("button_click_long_press_detector: match");
    end else begin
      $display("button_click_long_press_detector: mismatch");
    end
    $finish;
  end

endmodule
